// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_OPEN_QUOTE   = 3'd0;
  localparam logic [2:0] ERR_UNTERM_STR   = 3'd1;
  localparam logic [2:0] ERR_UNTERM_ESC   = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC      = 3'd3;
  localparam logic [2:0] ERR_SHORT_HEX    = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX      = 3'd5;
  localparam logic [2:0] ERR_MISSING_LOW  = 3'd6;
  localparam logic [2:0] ERR_BAD_PAIR     = 3'd7;

  localparam int MAX_DATA = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       begin_req;
    logic       input_end;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [2:0] err_code;
    logic       run_last;
  } jsu_out_t;

  // Everything one input byte produces: up to four data bytes, then an
  // optional closing or error result.
  typedef struct packed {
    logic [MAX_DATA-1:0][7:0] data;
    logic [2:0]               n_data;
    logic                     has_term;
    logic [1:0]               term_kind;
    logic [2:0]               term_code;
  } jsu_bundle_t;

  typedef struct packed {
    logic push;
    logic full;
  } jsu_wr_ctl_t;

  typedef struct packed {
    logic pop;
    logic head_valid;
  } jsu_rd_ctl_t;

endpackage

// ----- rtl/json_string_unescaper_core.sv -----
// Streaming JSON string unescaper: takes the raw bytes of one quoted string,
// one per transfer on the text channel, and returns decoded UTF-8 bytes, a
// closing marker, or one error code on the dec channel; run_last marks the
// last result of each input byte. The input side takes one byte per cycle
// as long as the result queue (DEPTH entries) has room. The output side
// delivers one result per cycle unless the queue is empty or a low dec_ready
// stalls it; a \uXXXX escape yields up to three bytes and a surrogate
// pair four, each possibly followed by an error. Bytes that yield nothing
// never reach the queue. The first result of a byte passes through the
// result queue and then the output register before it is presented on the
// dec channel.
module json_string_unescaper_core #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  output logic              text_ready,
  input  jsu_pkg::jsu_in_t  text_item,
  output logic              dec_valid,
  input  logic              dec_ready,
  output jsu_pkg::jsu_out_t dec_item
);
  import jsu_pkg::*;

  logic        push;
  logic        pop;
  jsu_bundle_t wr_bundle;
  jsu_bundle_t head;
  jsu_wr_ctl_t wr_ctl;
  jsu_rd_ctl_t rd_ctl;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_item  (text_item),
    .q_full     (wr_ctl.full),
    .q_push     (push),
    .q_bundle   (wr_bundle)
  );

  jsu_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (wr_bundle),
    .pop       (pop),
    .wr_ctl    (wr_ctl),
    .rd_ctl    (rd_ctl),
    .head      (head)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_ctl    (rd_ctl),
    .head      (head),
    .pop       (pop),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_item  (dec_item)
  );

endmodule

// ----- rtl/jsu_front.sv -----
module jsu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_ready,
  input  jsu_pkg::jsu_in_t    text_item,
  input  logic                q_full,
  output logic                q_push,
  output jsu_pkg::jsu_bundle_t q_bundle
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_HALT,
    PH_TEXT,
    PH_ESC,
    PH_HEX,
    PH_WANT_BS,
    PH_WANT_U
  } phase_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  phase_t      phase, phase_next;
  logic [15:0] hex_value, hex_value_next;
  logic [1:0]  digit_count, digit_count_next;
  logic        bad_digit_seen, bad_digit_seen_next;
  logic [9:0]  high_half, high_half_next;
  logic        in_low_escape, in_low_escape_next;

  logic        accept;
  logic [7:0]  c;
  logic        is_end;
  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] hex_full;
  logic [20:0] pair_cp;
  jsu_bundle_t b;

  assign text_ready = !q_full;
  assign accept     = text_valid && text_ready;
  assign c          = text_item.in_byte;
  assign is_end     = text_item.input_end;

  always_comb begin
    digit    = 4'd0;
    digit_ok = 1'b1;
    if (c inside {[8'h30:8'h39]}) begin
      digit = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      digit = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      digit = 4'(c - 8'h37);
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign hex_full = {hex_value[11:0], digit};
  assign pair_cp  = 21'h10000 + {1'b0, high_half, 10'd0} + {11'd0, hex_full[9:0]};

  always_comb begin
    phase_next          = phase;
    hex_value_next      = hex_value;
    digit_count_next    = digit_count;
    bad_digit_seen_next = bad_digit_seen;
    high_half_next      = high_half;
    in_low_escape_next  = in_low_escape;
    b                   = '0;

    if (text_item.begin_req) begin
      hex_value_next      = '0;
      digit_count_next    = '0;
      bad_digit_seen_next = 1'b0;
      high_half_next      = '0;
      in_low_escape_next  = 1'b0;
      if (c != CH_QUOTE) begin
        b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_OPEN_QUOTE;
        phase_next = PH_HALT;
      end else if (is_end) begin
        b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_UNTERM_STR;
        phase_next = PH_HALT;
      end else begin
        phase_next = PH_TEXT;
      end
    end else begin
      case (phase)
        PH_TEXT: begin
          if (c == CH_QUOTE) begin
            b.has_term = 1'b1; b.term_kind = KIND_CLOSE;
            phase_next = PH_HALT;
          end else if (c == CH_BSLASH) begin
            phase_next = PH_ESC;
            if (is_end) begin
              b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_UNTERM_ESC;
              phase_next = PH_HALT;
            end
          end else begin
            b.data[0] = c;
            b.n_data  = 3'd1;
            if (is_end) begin
              b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_UNTERM_STR;
              phase_next = PH_HALT;
            end
          end
        end
        PH_ESC: begin
          if (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T}) begin
            case (c)
              CH_B:    b.data[0] = 8'h08;
              CH_F:    b.data[0] = 8'h0C;
              CH_N:    b.data[0] = 8'h0A;
              CH_R:    b.data[0] = 8'h0D;
              CH_T:    b.data[0] = 8'h09;
              default: b.data[0] = c;
            endcase
            b.n_data   = 3'd1;
            phase_next = PH_TEXT;
            if (is_end) begin
              b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_UNTERM_STR;
              phase_next = PH_HALT;
            end
          end else if (c == CH_U) begin
            phase_next          = PH_HEX;
            hex_value_next      = '0;
            digit_count_next    = '0;
            bad_digit_seen_next = 1'b0;
            in_low_escape_next  = 1'b0;
            if (is_end) begin
              b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_SHORT_HEX;
              phase_next = PH_HALT;
            end
          end else begin
            b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_BAD_ESC;
            phase_next = PH_HALT;
          end
        end
        PH_HEX: begin
          hex_value_next      = hex_full;
          bad_digit_seen_next = bad_digit_seen || !digit_ok;
          if (digit_count != 2'd3) begin
            digit_count_next = digit_count + 2'd1;
            if (is_end) begin
              b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_SHORT_HEX;
              phase_next = PH_HALT;
            end
          end else begin
            digit_count_next = 2'd0;
            if (bad_digit_seen || !digit_ok) begin
              b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_BAD_HEX;
              phase_next = PH_HALT;
            end else if (in_low_escape) begin
              in_low_escape_next = 1'b0;
              if (hex_full inside {[16'hDC00:16'hDFFF]}) begin
                b.data[0]  = {5'b11110, pair_cp[20:18]};
                b.data[1]  = {2'b10, pair_cp[17:12]};
                b.data[2]  = {2'b10, pair_cp[11:6]};
                b.data[3]  = {2'b10, pair_cp[5:0]};
                b.n_data   = 3'd4;
                phase_next = PH_TEXT;
                if (is_end) begin
                  b.has_term = 1'b1; b.term_kind = KIND_ERROR;
                  b.term_code = ERR_UNTERM_STR;
                  phase_next = PH_HALT;
                end
              end else begin
                b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_BAD_PAIR;
                phase_next = PH_HALT;
              end
            end else if (hex_full inside {[16'hD800:16'hDBFF]}) begin
              high_half_next = hex_full[9:0];
              phase_next     = PH_WANT_BS;
              if (is_end) begin
                b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_MISSING_LOW;
                phase_next = PH_HALT;
              end
            end else begin
              if (hex_full < 16'h0080) begin
                b.data[0] = hex_full[7:0];
                b.n_data  = 3'd1;
              end else if (hex_full < 16'h0800) begin
                b.data[0] = {3'b110, hex_full[10:6]};
                b.data[1] = {2'b10, hex_full[5:0]};
                b.n_data  = 3'd2;
              end else begin
                b.data[0] = {4'b1110, hex_full[15:12]};
                b.data[1] = {2'b10, hex_full[11:6]};
                b.data[2] = {2'b10, hex_full[5:0]};
                b.n_data  = 3'd3;
              end
              phase_next = PH_TEXT;
              if (is_end) begin
                b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_UNTERM_STR;
                phase_next = PH_HALT;
              end
            end
          end
        end
        PH_WANT_BS: begin
          if (c == CH_BSLASH && !is_end) begin
            phase_next = PH_WANT_U;
          end else begin
            b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_MISSING_LOW;
            phase_next = PH_HALT;
          end
        end
        PH_WANT_U: begin
          if (c == CH_U) begin
            phase_next          = PH_HEX;
            hex_value_next      = '0;
            digit_count_next    = '0;
            bad_digit_seen_next = 1'b0;
            in_low_escape_next  = 1'b1;
            if (is_end) begin
              b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_SHORT_HEX;
              phase_next = PH_HALT;
            end
          end else begin
            b.has_term = 1'b1; b.term_kind = KIND_ERROR; b.term_code = ERR_MISSING_LOW;
            phase_next = PH_HALT;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Bytes that produce no result (inside an escape, or while halted) are
  // absorbed here and never reach the queue.
  assign q_push   = accept && (b.has_term || (b.n_data != 3'd0));
  assign q_bundle = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HALT;
      hex_value      <= '0;
      digit_count    <= '0;
      bad_digit_seen <= 1'b0;
      high_half      <= '0;
      in_low_escape  <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      hex_value      <= hex_value_next;
      digit_count    <= digit_count_next;
      bad_digit_seen <= bad_digit_seen_next;
      high_half      <= high_half_next;
      in_low_escape  <= in_low_escape_next;
    end
  end

endmodule

// ----- rtl/jsu_fifo.sv -----
module jsu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  jsu_pkg::jsu_bundle_t wr_bundle,
  input  logic                 pop,
  output jsu_pkg::jsu_wr_ctl_t wr_ctl,
  output jsu_pkg::jsu_rd_ctl_t rd_ctl,
  output jsu_pkg::jsu_bundle_t head
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_bundle_t        mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign wr_ctl.push       = push;
  assign wr_ctl.full       = (count == CNT_W'(DEPTH));
  assign rd_ctl.pop        = pop;
  assign rd_ctl.head_valid = (count != '0);
  assign head              = mem[rd_ptr];

  assign do_push = push && !wr_ctl.full;
  assign do_pop  = pop && rd_ctl.head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/jsu_back.sv -----
module jsu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  jsu_pkg::jsu_rd_ctl_t rd_ctl,
  input  jsu_pkg::jsu_bundle_t head,
  output logic                 pop,
  output logic                 dec_valid,
  input  logic                 dec_ready,
  output jsu_pkg::jsu_out_t    dec_item
);
  import jsu_pkg::*;

  logic [2:0] pos;
  logic [2:0] n_res;
  logic       last;
  logic       load;
  jsu_out_t   cur;

  assign n_res = head.n_data + {2'b00, head.has_term};
  assign last  = (pos == n_res - 3'd1);
  assign load  = rd_ctl.head_valid && (!dec_valid || dec_ready);
  assign pop   = load && last;

  always_comb begin
    cur = '0;
    if (pos < head.n_data) begin
      cur.out_byte = head.data[pos[1:0]];
      cur.out_kind = KIND_DATA;
    end else begin
      cur.out_kind = head.term_kind;
      cur.err_code = (head.term_kind == KIND_ERROR) ? head.term_code : 3'd0;
    end
    cur.run_last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      dec_valid <= 1'b1;
      pos       <= last ? 3'd0 : pos + 3'd1;
    end else if (dec_ready) begin
      dec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec_item <= cur;
    end
  end

endmodule

// ----- rtl/jsu_checker.sv -----
module jsu_checker (
  input logic              clk,
  input logic              rst,
  input logic              text_valid,
  input logic              text_ready,
  input jsu_pkg::jsu_in_t  text_item,
  input logic              dec_valid,
  input logic              dec_ready,
  input jsu_pkg::jsu_out_t dec_item
);
  import jsu_pkg::*;

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !dec_valid)
    else $error("result valid right after reset");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec_item))
    else $error("stalled result changed or dropped");

  a_terminal_is_last: assert property (@(posedge clk) disable iff (rst)
    dec_valid && (dec_item.out_kind != KIND_DATA) |-> dec_item.run_last)
    else $error("closing or error result not last for its byte");

  a_non_data_zero_byte: assert property (@(posedge clk) disable iff (rst)
    dec_valid && (dec_item.out_kind != KIND_DATA) |-> dec_item.out_byte == 8'd0)
    else $error("non-data result carries a byte");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    dec_valid && (dec_item.out_kind != KIND_ERROR) |-> dec_item.err_code == 3'd0)
    else $error("error code set on a non-error result");

endmodule

bind json_string_unescaper_core jsu_checker u_jsu_checker (.*);

// ----- tb/json_unescape_checker.sv -----
module json_unescape_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  input  logic              text_ready,
  input  jsu_pkg::jsu_in_t  text_item,
  input  logic              dec_valid,
  input  logic              dec_ready,
  input  jsu_pkg::jsu_out_t dec_item,
  output int                errors,
  output int                pending,
  output int                live_items
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    SCAN_HALT,
    SCAN_TEXT,
    SCAN_ESC,
    SCAN_HEX,
    SCAN_WANT_BS,
    SCAN_WANT_U
  } scan_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  scan_t       scan = SCAN_HALT;
  logic [15:0] hex_acc = '0;
  logic [1:0]  hex_digits = '0;
  logic        hex_bad = 1'b0;
  logic [9:0]  hi_bits = '0;
  logic        low_pending = 1'b0;

  jsu_out_t step_q[$];
  jsu_out_t decoded_q[$];
  jsu_out_t want;
  int       mismatches = 0;
  int       results_seen = 0;
  int       live_count = 0;

  task automatic queue_result(input jsu_out_t r);
    step_q.insert(step_q.size(), r);
  endtask

  task automatic put_data(input logic [7:0] b);
    jsu_out_t r;
    r = '{out_byte: b, out_kind: KIND_DATA, err_code: '0, run_last: 1'b0};
    queue_result(r);
  endtask

  task automatic put_close();
    jsu_out_t r;
    r = '{out_byte: 8'h00, out_kind: KIND_CLOSE, err_code: '0, run_last: 1'b0};
    queue_result(r);
    scan = SCAN_HALT;
  endtask

  // An error always stops the scan until the next begin.
  task automatic put_error(input logic [2:0] code);
    jsu_out_t r;
    r = '{out_byte: 8'h00, out_kind: KIND_ERROR, err_code: code, run_last: 1'b0};
    queue_result(r);
    scan = SCAN_HALT;
  endtask

  task automatic text_resume(input logic fin);
    scan = SCAN_TEXT;
    if (fin) put_error(ERR_UNTERM_STR);
  endtask

  task automatic start_hex(input logic low);
    scan        = SCAN_HEX;
    hex_acc     = '0;
    hex_digits  = '0;
    hex_bad     = 1'b0;
    low_pending = low;
  endtask

  task automatic encode_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_data(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_data({3'b110, cp[10:6]});
      put_data({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_data({4'b1110, cp[15:12]});
      put_data({2'b10, cp[11:6]});
      put_data({2'b10, cp[5:0]});
    end else begin
      put_data({5'b11110, cp[20:18]});
      put_data({2'b10, cp[17:12]});
      put_data({2'b10, cp[11:6]});
      put_data({2'b10, cp[5:0]});
    end
  endtask

  task automatic decode_byte(input jsu_in_t it);
    logic [7:0] c;
    logic       fin;
    logic [7:0] esc;
    logic       esc_ok;
    logic [3:0] nib;
    c   = it.in_byte;
    fin = it.input_end;
    step_q.delete();
    if (it.begin_req) begin
      scan        = SCAN_HALT;
      hex_acc     = '0;
      hex_digits  = '0;
      hex_bad     = 1'b0;
      hi_bits     = '0;
      low_pending = 1'b0;
      if (c != CH_QUOTE) put_error(ERR_OPEN_QUOTE);
      else text_resume(fin);
    end else begin
      case (scan)
        SCAN_TEXT: begin
          if (c == CH_QUOTE) begin
            put_close();
          end else if (c == CH_BSLASH) begin
            scan = SCAN_ESC;
            if (fin) put_error(ERR_UNTERM_ESC);
          end else begin
            put_data(c);
            text_resume(fin);
          end
        end
        SCAN_ESC: begin
          esc_ok = 1'b1;
          esc    = c;
          case (c)
            CH_QUOTE, CH_BSLASH, "/": esc = c;
            "b": esc = 8'h08;
            "f": esc = 8'h0C;
            "n": esc = 8'h0A;
            "r": esc = 8'h0D;
            "t": esc = 8'h09;
            default: esc_ok = 1'b0;
          endcase
          if (esc_ok) begin
            put_data(esc);
            text_resume(fin);
          end else if (c == "u") begin
            start_hex(1'b0);
            if (fin) put_error(ERR_SHORT_HEX);
          end else begin
            put_error(ERR_BAD_ESC);
          end
        end
        SCAN_HEX: begin
          // Any byte fills a digit slot; a non-digit is only reported once
          // all four slots are taken.
          nib = 4'h0;
          if (c >= "0" && c <= "9") nib = 4'(c - "0");
          else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
          else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
          else hex_bad = 1'b1;
          hex_acc = {hex_acc[11:0], nib};
          if (hex_digits < 2'd3) begin
            hex_digits = hex_digits + 2'd1;
            if (fin) put_error(ERR_SHORT_HEX);
          end else begin
            hex_digits = '0;
            if (hex_bad) begin
              put_error(ERR_BAD_HEX);
            end else if (low_pending) begin
              low_pending = 1'b0;
              if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                encode_utf8(21'h10000 + {1'b0, hi_bits, hex_acc[9:0]});
                text_resume(fin);
              end else begin
                put_error(ERR_BAD_PAIR);
              end
            end else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
              hi_bits = hex_acc[9:0];
              scan    = SCAN_WANT_BS;
              if (fin) put_error(ERR_MISSING_LOW);
            end else begin
              encode_utf8({5'd0, hex_acc});
              text_resume(fin);
            end
          end
        end
        SCAN_WANT_BS: begin
          if (c == CH_BSLASH && !fin) scan = SCAN_WANT_U;
          else put_error(ERR_MISSING_LOW);
        end
        SCAN_WANT_U: begin
          if (c == "u") begin
            start_hex(1'b1);
            if (fin) put_error(ERR_SHORT_HEX);
          end else begin
            put_error(ERR_MISSING_LOW);
          end
        end
        default: ;
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
    foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (text_valid && text_ready) begin
        live_count++;
        decode_byte(text_item);
      end
      if (dec_valid && dec_ready) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d unexpected: byte %h kind %0d code %0d last %0b",
                     $time, results_seen, dec_item.out_byte, dec_item.out_kind,
                     dec_item.err_code, dec_item.run_last);
        end else begin
          want = decoded_q.pop_front();
          if (dec_item.out_byte !== want.out_byte || dec_item.out_kind !== want.out_kind ||
              dec_item.err_code !== want.err_code || dec_item.run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b",
                       $time, results_seen, want.out_byte, want.out_kind, want.err_code,
                       want.run_last, dec_item.out_byte, dec_item.out_kind,
                       dec_item.err_code, dec_item.run_last);
          end
        end
      end
    end
    errors     <= mismatches;
    pending    <= decoded_q.size();
    live_items <= live_count;
  end

endmodule

// ----- tb/json_string_unescaper_core_tb.sv -----
module json_string_unescaper_core_tb;
  import jsu_pkg::*;

  localparam int ITEMS_PER_PHASE = 60;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 20;

  logic     clk;
  logic     rst = 1'b1;
  logic     text_valid = 1'b0;
  logic     text_ready;
  jsu_in_t  text_item = '0;
  logic     dec_valid;
  logic     dec_ready = 1'b0;
  jsu_out_t dec_item;

  int errors;
  int pending;
  int live_items;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  int send_idle_tbl[4]  = '{0, 78, 0, 37};
  int recv_stall_tbl[4] = '{0, 0, 78, 37};

  logic [7:0] txt[$];

  json_string_unescaper_core dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_item  (text_item),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .dec_item   (dec_item)
  );

  json_unescape_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_item  (text_item),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .dec_item   (dec_item),
    .errors     (errors),
    .pending    (pending),
    .live_items (live_items)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) dec_ready <= 1'b0;
    else dec_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Ends the run if neither channel completes a transfer for too long.
  always @(posedge clk) begin
    if (rst || (text_valid && text_ready) || (dec_valid && dec_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic beg, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_item  <= '{in_byte: b, begin_req: beg, input_end: fin};
    text_valid <= 1'b1;
    do @(posedge clk); while (!text_ready);
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == 0, fin && i == s.len() - 1);
  endtask

  task automatic add_txt(input logic [7:0] b);
    txt.insert(txt.size(), b);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic up);
    if (n < 4'd10) return 8'h30 + n;
    return (up ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  task automatic add_hex_escape(input logic [15:0] v);
    add_txt(8'h5C);
    add_txt("u");
    for (int k = 3; k >= 0; k--) add_txt(hex_char(v[k*4 +: 4], 1'($urandom_range(0, 1))));
  endtask

  initial begin
    string      esc_set;
    int         tokens;
    int         tk;
    int         mode;
    int         cut;
    int         target;
    logic [7:0] c;
    logic [15:0] v;
    logic       end_last;

    esc_set = "\"\\/bfnrt";
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_text("\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0);
    send_text("x", 1'b0);
    // Bytes without a begin are dropped while halted.
    send_byte("q", 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_text("\"\\u0041\\u00e9\\u20AC\\uFFFF\\uD83D\\uDE00\"", 1'b0);
    send_text("\"\\uDC00\"", 1'b0);
    send_text("\"\\uDBFF\\uDFFF", 1'b1);
    send_text("\"\\u12G4\"", 1'b0);
    send_text("\"\\u\"00\"", 1'b0);
    send_text("\"\\u12", 1'b1);
    send_text("\"\\u", 1'b1);
    send_text("\"ab\\", 1'b1);
    send_text("\"\\n", 1'b1);
    send_text("\"", 1'b1);
    send_text("\"\\x\"", 1'b0);
    send_text("\"\\uD800x\"", 1'b0);
    send_text("\"\\uD800\\", 1'b1);
    send_text("\"\\uD800\\x", 1'b0);
    send_text("\"\\uD800", 1'b1);
    send_text("\"\\uD800\\u0041\"", 1'b0);
    send_text("\"\\uD800\\uDBFF\"", 1'b0);
    send_text("\"\\uD800\\u", 1'b1);
    send_text("\"abc", 1'b0);
    send_text("\"z\"", 1'b1);
    send_byte(8'h22, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h1F, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_text("\"\"", 1'b0);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_idle_tbl[p];
      recv_stall_pct = recv_stall_tbl[p];
      target = live_items + ITEMS_PER_PHASE;
      while (live_items < target) begin
        txt.delete();
        add_txt(8'h22);
        tokens = $urandom_range(1, 6);
        repeat (tokens) begin
          tk = $urandom_range(0, 29);
          case (tk)
            0, 1, 2, 3, 4, 5, 6, 7: begin
              c = 8'($urandom_range(8'h20, 8'h7E));
              if (c == 8'h22 || c == 8'h5C) c = "a";
              add_txt(c);
            end
            8, 9, 10: begin
              c = 8'($urandom_range(0, 255));
              if (c == 8'h22 || c == 8'h5C) c = 8'h7F;
              add_txt(c);
            end
            11, 12, 13, 14, 15: begin
              add_txt(8'h5C);
              add_txt(esc_set[$urandom_range(0, 7)]);
            end
            16, 17, 18, 19, 20: begin
              case ($urandom_range(0, 3))
                0: v = 16'($urandom_range(0, 16'h7F));
                1: v = 16'($urandom_range(16'h80, 16'h7FF));
                2: v = 16'($urandom_range(16'h800, 16'hFFFF));
                default: v = 16'($urandom_range(16'hDC00, 16'hDFFF));
              endcase
              // Keep lone high surrogates out of the clean tokens.
              if (v >= 16'hD800 && v <= 16'hDBFF) v = v ^ 16'h4000;
              add_hex_escape(v);
            end
            21, 22, 23, 24, 25, 26, 27: begin
              add_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
              add_hex_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            28: begin
              add_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
              if ($urandom_range(0, 1)) begin
                add_txt("x");
              end else begin
                add_txt(8'h5C);
                add_txt("n");
              end
            end
            default: begin
              add_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
              if ($urandom_range(0, 1)) add_hex_escape(16'($urandom_range(0, 16'hDBFF)));
              else add_hex_escape(16'($urandom_range(16'hE000, 16'hFFFF)));
            end
          endcase
        end
        add_txt(8'h22);

        mode = $urandom_range(0, 19);
        end_last = 1'b0;
        case (mode)
          0: txt[$urandom_range(1, txt.size() - 1)] = 8'($urandom_range(0, 255));
          1, 2: begin
            cut = $urandom_range(1, txt.size() - 1);
            while (txt.size() > cut) void'(txt.pop_back());
            end_last = (mode == 1);
          end
          3: txt[0] = 8'($urandom_range(0, 255));
          4: repeat ($urandom_range(1, 3)) add_txt(8'($urandom_range(0, 255)));
          default: end_last = ($urandom_range(0, 3) == 0);
        endcase
        foreach (txt[i])
          send_byte(txt[i], i == 0, end_last && i == txt.size() - 1);
      end
    end

    text_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescaper_core.sv
rtl/jsu_checker.sv
tb/json_unescape_checker.sv
tb/json_string_unescaper_core_tb.sv
